// File: design/rfc_pkg.sv
`timescale 1ns / 1ps

package rfc_pkg;

   localparam int MAX_LEN = 64;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int CNT_W   = ADDR_W + 1;

   typedef enum logic [0:0] {
      ST_LOAD,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic wr;       // store the accepted byte
      logic finish;   // accepted byte ends the string
      logic emit;     // read out the permuted string
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic issue_last;   // final buffer read of the string goes out now
   } sts_type;

endpackage

// File: design/rfc_ctrl.sv
`timescale 1ns / 1ps

module rfc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_in_last,
   output logic             req_stall,
   input  rfc_pkg::sts_type sts,
   output rfc_pkg::cmd_type cmd
);

   rfc_pkg::state_type state_ff;
   rfc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rfc_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_stall  = 1'b1;
      cmd.wr     = 1'b0;
      cmd.finish = 1'b0;
      cmd.emit   = 1'b0;
      unique case (state_ff)
         rfc_pkg::ST_LOAD: begin
            req_stall  = 1'b0;
            cmd.wr     = req_valid;
            cmd.finish = req_valid && req_in_last;
            if (req_valid && req_in_last) begin
               state_in = rfc_pkg::ST_EMIT;
            end
         end
         rfc_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.issue_last) begin
               state_in = rfc_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = rfc_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

// File: design/rfc_datapath.sv
`timescale 1ns / 1ps

module rfc_datapath (
   input  logic             clock,
   input  logic             reset,
   input  rfc_pkg::cmd_type cmd,
   output rfc_pkg::sts_type sts,
   input  logic [7:0]       req_in_byte,
   input  logic             csr_valid,
   input  logic             csr_decrypt_mode,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_last,
   output logic             rsp_overflowed
);

   localparam int AW = rfc_pkg::ADDR_W;
   localparam int CW = rfc_pkg::CNT_W;
   localparam logic [CW-1:0] MaxCount = CW'(rfc_pkg::MAX_LEN);

   logic [7:0]    mem [rfc_pkg::MAX_LEN];

   logic          csr_mode_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          seen_ff, seen_in;
   logic [CW-1:0] len_ff;
   logic          mode_ff;
   logic          ovf_ff;
   logic [AW-1:0] j_ff, j_in;
   logic          pend_ff, pend_in;
   logic          pend_last_ff;
   logic          pend_ovf_ff;
   logic [7:0]    ram_q_ff;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_byte_ff;
   logic          out_last_ff;
   logic          out_ovf_ff;

   logic          full;
   logic          load_out;
   logic          rd_en;
   logic          rd_last;
   logic [CW-1:0] j_ext;
   logic [CW-1:0] c0, c1;
   logic [CW-1:0] enc_addr, dec_addr, rd_addr;

   assign full  = (cnt_ff >= MaxCount);
   assign j_ext = {1'b0, j_ff};
   assign c0    = (len_ff + CW'(3)) >> 2;
   assign c1    = len_ff >> 1;

   always_comb begin
      if (j_ext < c0) begin
         enc_addr = j_ext << 2;
      end else if (j_ext < c0 + c1) begin
         enc_addr = ((j_ext - c0) << 1) + CW'(1);
      end else begin
         enc_addr = ((j_ext - c0 - c1) << 2) + CW'(2);
      end
      if (j_ff[0]) begin
         dec_addr = c0 + (j_ext >> 1);
      end else if (j_ff[1]) begin
         dec_addr = c0 + c1 + (j_ext >> 2);
      end else begin
         dec_addr = j_ext >> 2;
      end
      if (len_ff < CW'(3)) begin
         rd_addr = j_ext;
      end else if (mode_ff) begin
         rd_addr = dec_addr;
      end else begin
         rd_addr = enc_addr;
      end
   end

   assign load_out       = pend_ff && (!out_valid_ff || !rsp_stall);
   assign rd_en          = cmd.emit && (!pend_ff || load_out);
   assign rd_last        = (j_ext == len_ff - CW'(1));
   assign sts.issue_last = rd_en && rd_last;

   always_ff @(posedge clock) begin
      if (cmd.wr && !full) begin
         mem[cnt_ff[AW-1:0]] <= req_in_byte;
      end
      if (rd_en) begin
         ram_q_ff <= mem[rd_addr[AW-1:0]];
      end
   end

   always_comb begin
      cnt_in  = cnt_ff;
      seen_in = seen_ff;
      if (cmd.wr) begin
         if (full) begin
            seen_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + CW'(1);
         end
      end
      if (cmd.finish) begin
         cnt_in  = '0;
         seen_in = 1'b0;
      end

      j_in = j_ff;
      if (cmd.finish) begin
         j_in = '0;
      end else if (rd_en) begin
         j_in = j_ff + AW'(1);
      end

      pend_in = pend_ff;
      if (rd_en) begin
         pend_in = 1'b1;
      end else if (load_out) begin
         pend_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_mode_ff  <= 1'b0;
         cnt_ff       <= '0;
         seen_ff      <= 1'b0;
         j_ff         <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            csr_mode_ff <= csr_decrypt_mode;
         end
         cnt_ff       <= cnt_in;
         seen_ff      <= seen_in;
         j_ff         <= j_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         len_ff  <= full ? cnt_ff : cnt_ff + CW'(1);
         ovf_ff  <= seen_ff || full;
         mode_ff <= csr_mode_ff;
      end
      if (rd_en) begin
         pend_last_ff <= rd_last;
         pend_ovf_ff  <= rd_last && ovf_ff;
      end
      if (load_out) begin
         out_byte_ff <= ram_q_ff;
         out_last_ff <= pend_last_ff;
         out_ovf_ff  <= pend_ovf_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_out_last   = out_last_ff;
   assign rsp_overflowed = out_ovf_ff;

endmodule

// File: design/rail_fence_cipher_three_rail.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    req_in_byte, req_in_last
// rsp       out        rsp_valid/stall    rsp_out_byte, rsp_out_last, rsp_overflowed
// csr       in         csr_valid/ready    csr_decrypt_mode
//
// Accepted bytes are stored in the buffer; a string of n bytes then streams out at
// one byte per cycle while rsp is not stalled, set by the single read port of the
// 64-entry buffer, behind the buffer read register and the output register.
// Loading and emission of a string take turns.
// Reset clears control state only; the buffer is not cleared.
// A stall on rsp holds the output register and pauses buffer reads.

module rail_fence_cipher_three_rail (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic       rsp_overflowed,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_decrypt_mode
);

   rfc_pkg::cmd_type cmd;
   rfc_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   rfc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_last (req_in_last),
      .req_stall   (req_stall),
      .sts         (sts),
      .cmd         (cmd)
   );

   rfc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_in_byte      (req_in_byte),
      .csr_valid        (csr_valid),
      .csr_decrypt_mode (csr_decrypt_mode),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last),
      .rsp_overflowed   (rsp_overflowed)
   );

endmodule

// File: design/rfc_checker.sv
`timescale 1ns / 1ps

module rfc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_in_last,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last,
   input logic       rsp_overflowed
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_out_last) && $stable(rsp_overflowed))
      else $error("rsp payload changed under stall");

   a_ovf_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflowed |-> rsp_out_last)
      else $error("overflow flagged on a transfer that is not last");

   a_stall_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_in_last |=> req_stall)
      else $error("req taken while emitting a string");

   a_keep_loading: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_in_last |=> !req_stall)
      else $error("req stalled in the middle of a string");

endmodule

bind rail_fence_cipher_three_rail rfc_checker u_rfc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_in_last    (req_in_last),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_out_last   (rsp_out_last),
   .rsp_overflowed (rsp_overflowed)
);

// File: sim/tb_rail_fence_cipher_three_rail.sv
`timescale 1ns / 1ps

module tb_rail_fence_cipher_three_rail;

   localparam int          RESET_CYCLES  = 5;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          LONG_HOLD     = 300;
   localparam int          RANDOM_ITEMS  = 150;
   localparam int          CYCLE_LIMIT   = 200000;
   localparam logic        MODE_ENCRYPT  = 1'b0;
   localparam logic        MODE_DECRYPT  = 1'b1;

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
      logic       ovf;
   } rail_char_type;

   typedef struct packed {
      logic       cfg;
      logic       mode;
      logic [7:0] ch;
      logic       fin;
      logic       typed;
      logic [7:0] exp_ch;
   } dir_row_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       req_in_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic       rsp_overflowed;
   logic       csr_valid;
   logic       csr_ready;
   logic       csr_decrypt_mode;

   rail_char_type expected_chars [$];
   logic [7:0]    held_chars [rfc_pkg::MAX_LEN];
   int            held_count    = 0;
   logic          held_ovf      = 1'b0;
   logic          decrypt_sel   = MODE_ENCRYPT;
   int            mismatches    = 0;
   int            cycle_count   = 0;
   int            random_sent   = 0;
   int unsigned   req_gap_max   = 8;
   int unsigned   rsp_gap_max   = 8;
   bit            hold_rsp      = 1'b0;
   dir_row_type   directed_rows [21];

   rail_fence_cipher_three_rail i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_in_last      (req_in_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last),
      .rsp_overflowed   (rsp_overflowed),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_decrypt_mode (csr_decrypt_mode)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_rail_fence_cipher_three_rail: FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
      mismatches++;
   endtask

   // store one byte; on the last byte, permute the string and queue its bytes
   task automatic absorb_char(input logic [7:0] ch, input logic fin);
      int            n;
      int            slot;
      int            order [rfc_pkg::MAX_LEN];
      logic [7:0]    permuted [rfc_pkg::MAX_LEN];
      rail_char_type rc;
      if (held_count < rfc_pkg::MAX_LEN) begin
         held_chars[held_count] = ch;
         held_count++;
      end else begin
         held_ovf = 1'b1;
      end
      if (fin) begin
         n    = held_count;
         slot = 0;
         for (int p = 0; p < n; p += 4) begin
            order[slot] = p;
            slot++;
         end
         for (int p = 1; p < n; p += 2) begin
            order[slot] = p;
            slot++;
         end
         for (int p = 2; p < n; p += 4) begin
            order[slot] = p;
            slot++;
         end
         for (int k = 0; k < n; k++) begin
            permuted[k] = held_chars[k];
         end
         if (n >= 3) begin
            for (int k = 0; k < n; k++) begin
               if (decrypt_sel == MODE_DECRYPT) begin
                  permuted[order[k]] = held_chars[k];
               end else begin
                  permuted[k] = held_chars[order[k]];
               end
            end
         end
         for (int k = 0; k < n; k++) begin
            rc.data = permuted[k];
            rc.fin  = (k == n - 1);
            rc.ovf  = (k == n - 1) && held_ovf;
            expected_chars.push_back(rc);
         end
         held_count = 0;
         held_ovf   = 1'b0;
      end
   endtask

   task automatic send_char(input logic [7:0] ch, input logic fin, input int unsigned gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= ch;
      req_in_last <= fin;
      do @(posedge clock); while (req_stall);
      absorb_char(ch, fin);
   endtask

   task automatic send_string(input int len);
      for (int i = 0; i < len; i++) begin
         send_char(8'($urandom_range(255, 0)), i == len - 1, $urandom_range(req_gap_max, 0));
         random_sent++;
      end
   endtask

   // hold the sender until every queued byte has arrived and the block is quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      drain();
      csr_valid        <= 1'b1;
      csr_decrypt_mode <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      decrypt_sel  = m;
   endtask

   always @(posedge clock) begin
      rail_char_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            report_mismatch("unexpected transfer, byte", rsp_out_byte, 0);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_out_byte !== want.data) begin
               report_mismatch("out_byte", rsp_out_byte, want.data);
            end
            if (rsp_out_last !== want.fin) begin
               report_mismatch("out_last", rsp_out_last, want.fin);
            end
            if (rsp_overflowed !== want.ovf) begin
               report_mismatch("overflowed", rsp_overflowed, want.ovf);
            end
         end
      end
   end

   initial begin
      int unsigned w;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            w = $urandom_range(rsp_gap_max, 0);
            if (w != 0) begin
               rsp_stall <= 1'b1;
               repeat (w) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   initial begin
      dir_row_type   row;
      rail_char_type known;
      int            phase;
      int            len;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_in_byte      <= 8'h00;
      req_in_last      <= 1'b0;
      csr_valid        <= 1'b0;
      csr_decrypt_mode <= MODE_ENCRYPT;
      directed_rows = '{
         '{1'b0, MODE_ENCRYPT, 8'h00, 1'b1, 1'b1, 8'h00},
         '{1'b0, MODE_ENCRYPT, 8'hFF, 1'b1, 1'b1, 8'hFF},
         '{1'b0, MODE_ENCRYPT, 8'hA5, 1'b0, 1'b0, 8'h00},
         '{1'b0, MODE_ENCRYPT, 8'h5A, 1'b1, 1'b0, 8'h00},
         '{1'b0, MODE_ENCRYPT, 8'h61, 1'b0, 1'b0, 8'h00},
         '{1'b0, MODE_ENCRYPT, 8'h62, 1'b0, 1'b0, 8'h00},
         '{1'b0, MODE_ENCRYPT, 8'h63, 1'b1, 1'b0, 8'h00},
         '{1'b1, MODE_DECRYPT, 8'h41, 1'b0, 1'b0, 8'h00},
         '{1'b0, MODE_DECRYPT, 8'h42, 1'b0, 1'b0, 8'h00},
         '{1'b0, MODE_DECRYPT, 8'h43, 1'b0, 1'b0, 8'h00},
         '{1'b0, MODE_DECRYPT, 8'h44, 1'b0, 1'b0, 8'h00},
         '{1'b0, MODE_DECRYPT, 8'h45, 1'b1, 1'b0, 8'h00},
         '{1'b0, MODE_DECRYPT, 8'h7F, 1'b1, 1'b1, 8'h7F},
         '{1'b0, MODE_DECRYPT, 8'h12, 1'b0, 1'b0, 8'h00},
         '{1'b0, MODE_DECRYPT, 8'h34, 1'b1, 1'b0, 8'h00},
         '{1'b1, MODE_ENCRYPT, 8'hFF, 1'b0, 1'b0, 8'h00},
         '{1'b0, MODE_ENCRYPT, 8'h00, 1'b0, 1'b0, 8'h00},
         '{1'b0, MODE_ENCRYPT, 8'hAA, 1'b0, 1'b0, 8'h00},
         '{1'b0, MODE_ENCRYPT, 8'h55, 1'b0, 1'b0, 8'h00},
         '{1'b0, MODE_ENCRYPT, 8'h01, 1'b0, 1'b0, 8'h00},
         '{1'b0, MODE_ENCRYPT, 8'hFE, 1'b1, 1'b0, 8'h00}
      };
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.cfg) begin
            write_mode(row.mode);
         end
         send_char(row.ch, row.fin, $urandom_range(req_gap_max, 0));
         if (row.typed) begin
            known.data = row.exp_ch;
            known.fin  = 1'b1;
            known.ovf  = 1'b0;
            void'(expected_chars.pop_back());
            expected_chars.push_back(known);
         end
      end

      phase = 0;
      while (random_sent < RANDOM_ITEMS || phase < 4) begin
         if ($urandom_range(3, 0) == 0) begin
            write_mode($urandom_range(1, 0) ? MODE_DECRYPT : MODE_ENCRYPT);
         end
         req_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 8;
         rsp_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 8;
         if (phase == 1) begin
            req_gap_max = 0;
            rsp_gap_max = 0;
            send_string(rfc_pkg::MAX_LEN);
         end else if (phase == 3) begin
            // overrun the buffer while the receiver holds off, then keep offering
            drain();
            hold_rsp = 1'b1;
            send_string(rfc_pkg::MAX_LEN + 2);
            send_string(5);
         end else begin
            len = ($urandom_range(9, 0) == 0) ? $urandom_range(rfc_pkg::MAX_LEN - 1, 13)
                                              : $urandom_range(12, 1);
            send_string(len);
         end
         if (phase == 2) begin
            drain();
         end
         phase++;
      end

      drain();
      if (mismatches == 0) begin
         $display("tb_rail_fence_cipher_three_rail: PASS");
      end else begin
         $display("tb_rail_fence_cipher_three_rail: FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/rfc_pkg.sv
design/rfc_ctrl.sv
design/rfc_datapath.sv
design/rail_fence_cipher_three_rail.sv
design/rfc_checker.sv
sim/tb_rail_fence_cipher_three_rail.sv
